@@ rtl/bpc_pkg.sv @@
// ---------------------------------------------------------------------------
// bpc_pkg : shared constants and helpers for pressure compensation
// Register indexes, fixed coefficients and the signed power-of-two divide.
// ---------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  // configuration register indexes
  localparam logic [2:0] RegOfsGain  = 3'd0;
  localparam logic [2:0] RegSens     = 3'd1;
  localparam logic [2:0] RegTscale   = 3'd2;
  localparam logic [2:0] RegSecond   = 3'd3;
  localparam logic [2:0] RegCurve    = 3'd4;

  // oversampling setting (0..3)
  localparam logic [1:0]  Oss        = 2'd0;

  // divider geometry and sideband width
  localparam int          DivSteps   = 32;
  localparam int          SideW      = 64;

  // fixed formula constants
  localparam logic [31:0] TempBias   = 32'd4000;
  localparam logic [31:0] PresScale  = 32'd50000 >> Oss;
  localparam logic [31:0] SensBias   = 32'd32768;
  localparam logic [31:0] CurveA     = 32'd3038;
  localparam logic [31:0] CurveB     = 32'hFFFF_E343;   // -7357
  localparam logic [31:0] CurveC     = 32'd3791;

  // signed divide by 2^k, truncating toward zero
  function automatic logic [31:0] sdiv_pow2(input logic [31:0] a, input logic [4:0] k);
    logic [31:0] mag;
    logic [31:0] q;
    mag = a[31] ? (32'd0 - a) : a;
    q   = mag >> k;
    return a[31] ? (32'd0 - q) : q;
  endfunction

  // sign extend a 16-bit coefficient
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

`default_nettype wire

@@ rtl/barometric_pressure_compensation_top.sv @@
// ---------------------------------------------------------------------------
// barometric_pressure_compensation_top : pressure/temperature compensation
// Turns raw temperature and pressure readings into 0.1 degC and pascal.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_stall carries one word: raw temperature and
//    raw pressure. Result channel out_valid/out_stall carries temperature,
//    pressure and divide_error. A word moves when valid is high and stall
//    is low.
//  - Calibration is written over cfg_valid/cfg_ready (ready always high),
//    cfg_index selects one of five coefficient pairs. Write only when idle.
//  - From acceptance to out_valid a word passes 3 front stages, a
//    32-stage divider, 7 middle stages, a second 32-stage divider and 4
//    back stages. One word is accepted every cycle unless in_stall is high.
//  - The whole pipe advances together; while a result is held by out_stall
//    every stage freezes and in_stall is raised, nothing is dropped.
//  - Reset clears all valid bits and the coefficient registers to zero.
//  - A zero divisor yields zero outputs with divide_error set.
// ---------------------------------------------------------------------------
`default_nettype none

module barometric_pressure_compensation_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_raw_temperature,
  input  wire logic [18:0] in_raw_pressure,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_temperature,
  output logic [31:0]      out_pressure,
  output logic             out_divide_error,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // coefficient registers
  logic [31:0] ofs_gain_r, sens_r, tscale_r, second_r, curve_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_gain_r <= '0;
      sens_r     <= '0;
      tscale_r   <= '0;
      second_r   <= '0;
      curve_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bpc_pkg::RegOfsGain: ofs_gain_r <= cfg_data;
        bpc_pkg::RegSens:    sens_r     <= cfg_data;
        bpc_pkg::RegTscale:  tscale_r   <= cfg_data;
        bpc_pkg::RegSecond:  second_r   <= cfg_data;
        bpc_pkg::RegCurve:   curve_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bpc_pkg::sx16(ofs_gain_r[31:16]);
  assign ac2 = bpc_pkg::sx16(ofs_gain_r[15:0]);
  assign ac3 = bpc_pkg::sx16(sens_r[31:16]);
  assign ac4 = {16'd0, sens_r[15:0]};
  assign ac5 = {16'd0, tscale_r[31:16]};
  assign ac6 = {16'd0, tscale_r[15:0]};
  assign b1  = bpc_pkg::sx16(second_r[31:16]);
  assign b2  = bpc_pkg::sx16(second_r[15:0]);
  assign mc  = bpc_pkg::sx16(curve_r[31:16]);
  assign md  = bpc_pkg::sx16(curve_r[15:0]);

  // global advance: freeze while the result word is held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // valid bits of the non-divider stages
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;
  logic v11_r, v12_r, v13_r, v14_r;
  logic d1_vld, d2_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0; v10_r <= 1'b0;
      v11_r <= 1'b0; v12_r <= 1'b0; v13_r <= 1'b0; v14_r <= 1'b0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= d1_vld;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= d2_vld;
      v12_r <= v11_r;
      v13_r <= v12_r;
      v14_r <= v13_r;
    end
  end

  // stage 1: temperature product
  logic [31:0] s1_a_r;
  logic [18:0] s1_up_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r  <= ({16'd0, in_raw_temperature} - ac6) * ac5;
      s1_up_r <= in_raw_pressure;
    end
  end

  // stage 2: x1 and divisor
  logic [31:0] s2_x1_r, s2_den_r;
  logic [18:0] s2_up_r;
  logic [31:0] x1_nxt;
  assign x1_nxt = bpc_pkg::sdiv_pow2(s1_a_r, 5'd15);
  always_ff @(posedge clk) begin
    if (en) begin
      s2_x1_r  <= x1_nxt;
      s2_den_r <= x1_nxt + md;
      s2_up_r  <= s1_up_r;
    end
  end

  // stage 3: magnitudes and sign for the curvature divide
  logic [31:0] s3_mn_r, s3_md_r, s3_x1_r;
  logic [18:0] s3_up_r;
  logic        s3_sgn_r, s3_dz_r;
  logic [31:0] cnum;
  assign cnum = {mc[20:0], 11'd0};
  always_ff @(posedge clk) begin
    if (en) begin
      s3_mn_r  <= cnum[31] ? (32'd0 - cnum) : cnum;
      s3_md_r  <= s2_den_r[31] ? (32'd0 - s2_den_r) : s2_den_r;
      s3_sgn_r <= cnum[31] ^ s2_den_r[31];
      s3_dz_r  <= (s2_den_r == 32'd0);
      s3_x1_r  <= s2_x1_r;
      s3_up_r  <= s2_up_r;
    end
  end

  // divider 1
  logic [31:0]                d1_quo;
  logic [bpc_pkg::SideW-1:0]  d1_side_in, d1_side;
  assign d1_side_in = {11'd0, s3_x1_r, s3_up_r, s3_sgn_r, s3_dz_r};

  bpc_div u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v3_r),
    .in_num   (s3_mn_r),
    .in_den   (s3_md_r),
    .in_side  (d1_side_in),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  // stage 4: b5, temperature, b6
  logic [31:0] d1_x1, x2_t, b5;
  logic [18:0] d1_up;
  assign d1_x1 = d1_side[52:21];
  assign d1_up = d1_side[20:2];
  assign x2_t  = d1_side[1] ? (32'd0 - d1_quo) : d1_quo;
  assign b5    = d1_x1 + x2_t;

  logic [31:0] s4_t_r, s4_b6_r;
  logic [18:0] s4_up_r;
  logic        s4_dz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_t_r  <= bpc_pkg::sdiv_pow2(b5 + 32'd8, 5'd4);
      s4_b6_r <= b5 - bpc_pkg::TempBias;
      s4_up_r <= d1_up;
      s4_dz_r <= d1_side[0];
    end
  end

  // stage 5: products of b6
  logic [31:0] s5_sq_r, s5_a2_r, s5_a3_r, s5_t_r;
  logic [18:0] s5_up_r;
  logic        s5_dz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_sq_r <= s4_b6_r * s4_b6_r;
      s5_a2_r <= ac2 * s4_b6_r;
      s5_a3_r <= ac3 * s4_b6_r;
      s5_t_r  <= s4_t_r;
      s5_up_r <= s4_up_r;
      s5_dz_r <= s4_dz_r;
    end
  end

  // stage 6: scale
  logic [31:0] s6_sq_r, s6_x2a_r, s6_x1c_r, s6_t_r;
  logic [18:0] s6_up_r;
  logic        s6_dz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s6_sq_r  <= bpc_pkg::sdiv_pow2(s5_sq_r, 5'd12);
      s6_x2a_r <= bpc_pkg::sdiv_pow2(s5_a2_r, 5'd11);
      s6_x1c_r <= bpc_pkg::sdiv_pow2(s5_a3_r, 5'd13);
      s6_t_r   <= s5_t_r;
      s6_up_r  <= s5_up_r;
      s6_dz_r  <= s5_dz_r;
    end
  end

  // stage 7: quadratic products
  logic [31:0] s7_b2sq_r, s7_b1sq_r, s7_x2a_r, s7_x1c_r, s7_t_r;
  logic [18:0] s7_up_r;
  logic        s7_dz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s7_b2sq_r <= b2 * s6_sq_r;
      s7_b1sq_r <= b1 * s6_sq_r;
      s7_x2a_r  <= s6_x2a_r;
      s7_x1c_r  <= s6_x1c_r;
      s7_t_r    <= s6_t_r;
      s7_up_r   <= s6_up_r;
      s7_dz_r   <= s6_dz_r;
    end
  end

  // stage 8: b3 and sensitivity term
  function automatic logic [4:0] Oss_w();
    return {3'd0, bpc_pkg::Oss};
  endfunction

  logic [31:0] x3_a, b3_pre, x2_b;
  assign x3_a   = bpc_pkg::sdiv_pow2(s7_b2sq_r, 5'd11) + s7_x2a_r;
  assign b3_pre = ((32'(ac1 << 2) + x3_a) << Oss_w()) + 32'd2;
  assign x2_b   = bpc_pkg::sdiv_pow2(s7_b1sq_r, 5'd16);

  logic [31:0] s8_b3_r, s8_x3_r, s8_t_r;
  logic [18:0] s8_up_r;
  logic        s8_dz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s8_b3_r <= bpc_pkg::sdiv_pow2(b3_pre, 5'd2);
      s8_x3_r <= bpc_pkg::sdiv_pow2(s7_x1c_r + x2_b + 32'd2, 5'd2);
      s8_t_r  <= s7_t_r;
      s8_up_r <= s7_up_r;
      s8_dz_r <= s7_dz_r;
    end
  end

  // stage 9: b4 and b7 products
  logic [31:0] s9_b4m_r, s9_b7_r, s9_t_r;
  logic        s9_dz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s9_b4m_r <= ac4 * (s8_x3_r + bpc_pkg::SensBias);
      s9_b7_r  <= ({13'd0, s8_up_r} - s8_b3_r) * bpc_pkg::PresScale;
      s9_t_r   <= s8_t_r;
      s9_dz_r  <= s8_dz_r;
    end
  end

  // stage 10: divider operands for the pressure divide
  logic [31:0] s10_num_r, s10_den_r, s10_t_r;
  logic        s10_neg_r, s10_err_r;
  logic [31:0] b4;
  assign b4 = {15'd0, s9_b4m_r[31:15]};
  always_ff @(posedge clk) begin
    if (en) begin
      s10_num_r <= s9_b7_r[31] ? s9_b7_r : {s9_b7_r[30:0], 1'b0};
      s10_den_r <= b4;
      s10_neg_r <= s9_b7_r[31];
      s10_err_r <= s9_dz_r || (b4 == 32'd0);
      s10_t_r   <= s9_t_r;
    end
  end

  // divider 2
  logic [31:0]                d2_quo;
  logic [bpc_pkg::SideW-1:0]  d2_side_in, d2_side;
  assign d2_side_in = {30'd0, s10_t_r, s10_neg_r, s10_err_r};

  bpc_div u_div_p (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v10_r),
    .in_num   (s10_num_r),
    .in_den   (s10_den_r),
    .in_side  (d2_side_in),
    .out_vld  (d2_vld),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  // stage 11: raw pressure
  logic [31:0] p_raw;
  assign p_raw = d2_side[1] ? {d2_quo[30:0], 1'b0} : d2_quo;

  logic [31:0] s11_p_r, s11_pp_r, s11_t_r;
  logic        s11_err_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s11_p_r   <= p_raw;
      s11_pp_r  <= bpc_pkg::sdiv_pow2(p_raw, 5'd8);
      s11_t_r   <= d2_side[33:2];
      s11_err_r <= d2_side[0];
    end
  end

  // stage 12: correction products
  logic [31:0] s12_p_r, s12_sq_r, s12_m2_r, s12_t_r;
  logic        s12_err_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s12_sq_r  <= s11_pp_r * s11_pp_r;
      s12_m2_r  <= bpc_pkg::CurveB * s11_p_r;
      s12_p_r   <= s11_p_r;
      s12_t_r   <= s11_t_r;
      s12_err_r <= s11_err_r;
    end
  end

  // stage 13: second correction product
  logic [31:0] s13_p_r, s13_m1_r, s13_m2_r, s13_t_r;
  logic        s13_err_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s13_m1_r  <= s12_sq_r * bpc_pkg::CurveA;
      s13_m2_r  <= s12_m2_r;
      s13_p_r   <= s12_p_r;
      s13_t_r   <= s12_t_r;
      s13_err_r <= s12_err_r;
    end
  end

  // stage 14: final sum into the output word
  logic [31:0] corr;
  assign corr = bpc_pkg::sdiv_pow2(bpc_pkg::sdiv_pow2(s13_m1_r, 5'd16)
              + bpc_pkg::sdiv_pow2(s13_m2_r, 5'd16) + bpc_pkg::CurveC, 5'd4);

  logic [31:0] out_t_r, out_p_r;
  logic        out_err_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_t_r   <= s13_err_r ? 32'd0 : s13_t_r;
      out_p_r   <= s13_err_r ? 32'd0 : (s13_p_r + corr);
      out_err_r <= s13_err_r;
    end
  end

  assign out_valid        = v14_r;
  assign out_temperature  = out_t_r;
  assign out_pressure     = out_p_r;
  assign out_divide_error = out_err_r;

endmodule

`default_nettype wire

@@ rtl/bpc_div.sv @@
// ---------------------------------------------------------------------------
// bpc_div : pipelined unsigned 32/32 divider
// Restoring division, one quotient bit per stage, with a sideband word
// that travels alongside. All stages advance together on en.
// ---------------------------------------------------------------------------
`default_nettype none

module bpc_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_vld,
  input  wire logic [31:0]              in_num,
  input  wire logic [31:0]              in_den,
  input  wire logic [bpc_pkg::SideW-1:0] in_side,
  output logic                          out_vld,
  output logic [31:0]                   out_quo,
  output logic [bpc_pkg::SideW-1:0]     out_side
);

  localparam int N = bpc_pkg::DivSteps;

  logic [31:0]               rem_r  [N];
  logic [31:0]               num_r  [N];
  logic [31:0]               den_r  [N];
  logic [31:0]               quo_r  [N];
  logic [bpc_pkg::SideW-1:0] side_r [N];
  logic                      vld_r  [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [31:0]               rem_in;
    logic [31:0]               num_in;
    logic [31:0]               den_in;
    logic [31:0]               quo_in;
    logic [bpc_pkg::SideW-1:0] side_in;
    logic                      vld_in;
    logic [32:0]               sh;
    logic [32:0]               dif;

    if (i == 0) begin : g_first
      assign rem_in  = 32'd0;
      assign num_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = 32'd0;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign num_in  = num_r[i-1];
      assign den_in  = den_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    // shift in next dividend bit and trial subtract
    assign sh  = {rem_in, num_in[31]};
    assign dif = sh - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= dif[32] ? sh[31:0] : dif[31:0];
        quo_r[i]  <= {quo_in[30:0], ~dif[32]};
        num_r[i]  <= {num_in[30:0], 1'b0};
        den_r[i]  <= den_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_quo  = quo_r[N-1];
  assign out_side = side_r[N-1];

endmodule

`default_nettype wire
